// ===== src/line_segment_window_clipper_macros.svh =====
// Assertion macros shared by the clipper RTL.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`ifndef ASSERT_OFF
`define LSW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsw assertion failed");
`define LSW_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lsw forbidden condition");
`else
`define LSW_ASSERT(lbl, prop)
`define LSW_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== src/lsw_pkg.sv =====
// Shared types and constants of the line segment window clipper.
package lsw_pkg;

    localparam int CoordBits       = 16;
    localparam int FracBitsDefault = 16;
    localparam int CfgIndexBits    = 2;

    localparam logic [CfgIndexBits-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CfgIndexBits-1:0] CFG_RIGHT  = 2'd1;
    localparam logic [CfgIndexBits-1:0] CFG_BOTTOM = 2'd2;
    localparam logic [CfgIndexBits-1:0] CFG_TOP    = 2'd3;

    localparam logic signed [CoordBits-1:0] LeftReset   = 16'sd0;
    localparam logic signed [CoordBits-1:0] RightReset  = 16'sd300;
    localparam logic signed [CoordBits-1:0] BottomReset = 16'sd0;
    localparam logic signed [CoordBits-1:0] TopReset    = 16'sd300;

    typedef enum logic [1:0] {
        KIND_ENTRY,
        KIND_EXIT,
        KIND_PAR_OK,
        KIND_PAR_BAD
    } edge_kind_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] start_x;
        logic signed [CoordBits-1:0] start_y;
        logic signed [CoordBits-1:0] end_x;
        logic signed [CoordBits-1:0] end_y;
    } seg_in_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] clip_start_x;
        logic signed [CoordBits-1:0] clip_start_y;
        logic signed [CoordBits-1:0] clip_end_x;
        logic signed [CoordBits-1:0] clip_end_y;
        logic                        visible;
    } seg_out_t;

endpackage

// ===== src/lsw_div_lane.sv =====
// One boundary test lane: p/q classification and pipelined restoring divider.
module lsw_div_lane #(
    parameter int FRAC_BITS = lsw_pkg::FracBitsDefault
) (
    input  logic                                clk,
    input  logic [FRAC_BITS:0]                  en,
    input  logic signed [lsw_pkg::CoordBits:0]  p,
    input  logic signed [lsw_pkg::CoordBits:0]  q,
    output lsw_pkg::edge_kind_t                 kind,
    output logic signed [FRAC_BITS+1:0]         r
);
    import lsw_pkg::*;

    localparam int DW = CoordBits + 1;
    localparam int RW = FRAC_BITS + 2;

    typedef enum logic [1:0] {
        CODE_NEG,
        CODE_OVER,
        CODE_ONE,
        CODE_DIV
    } code_t;

    code_t                code_reg [0:FRAC_BITS];
    edge_kind_t           kind_reg [0:FRAC_BITS];
    logic [CoordBits-1:0] d_reg    [0:FRAC_BITS];
    logic [CoordBits-1:0] rem_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg  [0:FRAC_BITS];

    logic signed [DW-1:0] n_val;
    logic signed [DW-1:0] d_val;
    code_t                code_val;
    edge_kind_t           kind_val;

    always_comb
    begin
        n_val = (p < 0) ? -q : q;
        d_val = (p < 0) ? -p : p;
        if (p < 0)
            kind_val = KIND_ENTRY;
        else if (p > 0)
            kind_val = KIND_EXIT;
        else if (q < 0)
            kind_val = KIND_PAR_BAD;
        else
            kind_val = KIND_PAR_OK;
        if (n_val < 0)
            code_val = CODE_NEG;
        else if (n_val > d_val)
            code_val = CODE_OVER;
        else if (n_val == d_val)
            code_val = CODE_ONE;
        else
            code_val = CODE_DIV;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            code_reg[0] <= code_val;
            kind_reg[0] <= kind_val;
            d_reg[0]    <= d_val[CoordBits-1:0];
            rem_reg[0]  <= n_val[CoordBits-1:0];
            quo_reg[0]  <= '0;
        end
    end

    for (genvar s = 1; s <= FRAC_BITS; s++)
    begin : g_step
        logic [CoordBits:0] shifted;
        logic [CoordBits:0] diff;
        logic               ge;

        always_comb
        begin
            shifted = {rem_reg[s-1], 1'b0};
            diff    = shifted - {1'b0, d_reg[s-1]};
            ge      = shifted >= {1'b0, d_reg[s-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                code_reg[s] <= code_reg[s-1];
                kind_reg[s] <= kind_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
                rem_reg[s]  <= ge ? diff[CoordBits-1:0] : shifted[CoordBits-1:0];
                quo_reg[s]  <= {quo_reg[s-1][FRAC_BITS-2:0], ge};
            end
        end
    end

    always_comb
    begin
        kind = kind_reg[FRAC_BITS];
        case (code_reg[FRAC_BITS])
            CODE_NEG:  r = '1;
            CODE_OVER: r = (RW'(1) << FRAC_BITS) + RW'(1);
            CODE_ONE:  r = RW'(1) << FRAC_BITS;
            CODE_DIV:  r = {2'b00, quo_reg[FRAC_BITS]};
            default:   r = '1;
        endcase
    end

endmodule

// ===== src/lsw_narrow.sv =====
// Four-stage narrowing of entry/exit parameters, one boundary per stage.
module lsw_narrow #(
    parameter int FRAC_BITS = lsw_pkg::FracBitsDefault
) (
    input  logic                        clk,
    input  logic [3:0]                  en,
    input  lsw_pkg::edge_kind_t         kind [4],
    input  logic signed [FRAC_BITS+1:0] r    [4],
    output logic                        ok,
    output logic signed [FRAC_BITS+1:0] u_in,
    output logic signed [FRAC_BITS+1:0] u_out
);
    import lsw_pkg::*;

    localparam int RW = FRAC_BITS + 2;

    logic              ok_reg   [0:3];
    logic signed [RW-1:0] uin_reg  [0:3];
    logic signed [RW-1:0] uout_reg [0:3];
    edge_kind_t        kind_reg [0:3][0:3];
    logic signed [RW-1:0] r_reg    [0:3][0:3];

    for (genvar s = 0; s < 4; s++)
    begin : g_test
        logic              src_ok;
        logic signed [RW-1:0] src_ui;
        logic signed [RW-1:0] src_uo;
        edge_kind_t        src_kind [0:3];
        logic signed [RW-1:0] src_r    [0:3];
        logic              ok_n;
        logic signed [RW-1:0] ui_n;
        logic signed [RW-1:0] uo_n;

        always_comb
        begin
            if (s == 0)
            begin
                src_ok = 1'b1;
                src_ui = '0;
                src_uo = RW'(1) << FRAC_BITS;
                for (int i = 0; i < 4; i++)
                begin
                    src_kind[i] = kind[i];
                    src_r[i]    = r[i];
                end
            end
            else
            begin
                src_ok = ok_reg[(s == 0) ? 0 : s-1];
                src_ui = uin_reg[(s == 0) ? 0 : s-1];
                src_uo = uout_reg[(s == 0) ? 0 : s-1];
                for (int i = 0; i < 4; i++)
                begin
                    src_kind[i] = kind_reg[(s == 0) ? 0 : s-1][i];
                    src_r[i]    = r_reg[(s == 0) ? 0 : s-1][i];
                end
            end
            ok_n = src_ok;
            ui_n = src_ui;
            uo_n = src_uo;
            case (src_kind[s])
                KIND_ENTRY:
                begin
                    if (src_r[s] > src_uo)
                        ok_n = 1'b0;
                    else if (src_r[s] > src_ui)
                        ui_n = src_r[s];
                end
                KIND_EXIT:
                begin
                    if (src_r[s] < src_ui)
                        ok_n = 1'b0;
                    else if (src_r[s] < src_uo)
                        uo_n = src_r[s];
                end
                KIND_PAR_BAD: ok_n = 1'b0;
                default: ;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                ok_reg[s]   <= ok_n;
                uin_reg[s]  <= ui_n;
                uout_reg[s] <= uo_n;
                for (int i = 0; i < 4; i++)
                begin
                    kind_reg[s][i] <= src_kind[i];
                    r_reg[s][i]    <= src_r[i];
                end
            end
        end
    end

    assign ok    = ok_reg[3];
    assign u_in  = uin_reg[3];
    assign u_out = uout_reg[3];

endmodule

// ===== src/line_segment_window_clipper.sv =====
// Throughput: one segment per cycle while out_stall is low; four pipelined
// restoring dividers, one quotient bit per stage, then one stage per boundary
// test, multiply, round.
// Reset: window returns to left 0, right 300, bottom 0, top 300; pipeline empties.
// Config port is always ready.
module line_segment_window_clipper #(
    parameter int FRAC_BITS = lsw_pkg::FracBitsDefault
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lsw_pkg::seg_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lsw_pkg::seg_out_t                    out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsw_pkg::CfgIndexBits-1:0]     cfg_index,
    input  logic signed [lsw_pkg::CoordBits-1:0] cfg_data
);
    import lsw_pkg::*;

    `include "line_segment_window_clipper_macros.svh"

    localparam int CB  = CoordBits;
    localparam int DW  = CB + 1;
    localparam int RW  = FRAC_BITS + 2;
    localparam int PW  = FRAC_BITS + CB + 3;
    localparam int NS  = FRAC_BITS + 8;
    localparam int NC  = FRAC_BITS + 6;
    localparam int DIV_FIRST = 1;
    localparam int NAR_FIRST = FRAC_BITS + 2;
    localparam int MUL_STAGE = FRAC_BITS + 6;
    localparam int OUT_STAGE = FRAC_BITS + 7;

    logic signed [CB-1:0] left_reg, right_reg, bottom_reg, top_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= LeftReset;
            right_reg  <= RightReset;
            bottom_reg <= BottomReset;
            top_reg    <= TopReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEFT:   left_reg   <= cfg_data;
                CFG_RIGHT:  right_reg  <= cfg_data;
                CFG_BOTTOM: bottom_reg <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and enables
    logic [NS-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS-2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NS; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[OUT_STAGE];

    // stage 0: deltas and boundary distances
    logic signed [CB-1:0] sx_pipe [0:NC-1];
    logic signed [CB-1:0] sy_pipe [0:NC-1];
    logic signed [DW-1:0] dx_pipe [0:NC-1];
    logic signed [DW-1:0] dy_pipe [0:NC-1];
    logic signed [DW-1:0] q_reg   [4];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sx_pipe[0] <= in_data.start_x;
            sy_pipe[0] <= in_data.start_y;
            dx_pipe[0] <= DW'(in_data.end_x) - DW'(in_data.start_x);
            dy_pipe[0] <= DW'(in_data.end_y) - DW'(in_data.start_y);
            q_reg[0]   <= DW'(in_data.start_x) - DW'(left_reg);
            q_reg[1]   <= DW'(right_reg) - DW'(in_data.start_x);
            q_reg[2]   <= DW'(in_data.start_y) - DW'(bottom_reg);
            q_reg[3]   <= DW'(top_reg) - DW'(in_data.start_y);
        end
        for (int k = 1; k < NC; k++)
        begin
            if (en[k])
            begin
                sx_pipe[k] <= sx_pipe[k-1];
                sy_pipe[k] <= sy_pipe[k-1];
                dx_pipe[k] <= dx_pipe[k-1];
                dy_pipe[k] <= dy_pipe[k-1];
            end
        end
    end

    logic signed [DW-1:0] p_val [4];
    edge_kind_t           lane_kind [4];
    logic signed [RW-1:0] lane_r    [4];

    assign p_val[0] = -dx_pipe[0];
    assign p_val[1] = dx_pipe[0];
    assign p_val[2] = -dy_pipe[0];
    assign p_val[3] = dy_pipe[0];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        lsw_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (en[DIV_FIRST+FRAC_BITS:DIV_FIRST]),
            .p    (p_val[i]),
            .q    (q_reg[i]),
            .kind (lane_kind[i]),
            .r    (lane_r[i])
        );
    end

    logic                 nar_ok;
    logic signed [RW-1:0] nar_uin, nar_uout;

    lsw_narrow #(
        .FRAC_BITS (FRAC_BITS)
    ) u_narrow (
        .clk   (clk),
        .en    (en[NAR_FIRST+3:NAR_FIRST]),
        .kind  (lane_kind),
        .r     (lane_r),
        .ok    (nar_ok),
        .u_in  (nar_uin),
        .u_out (nar_uout)
    );

    // multiply stage
    logic signed [PW-1:0] psx_reg, psy_reg, pex_reg, pey_reg;
    logic                 mok_reg;
    logic signed [CB-1:0] msx_reg, msy_reg;
    logic signed [DW-1:0] mdx_reg, mdy_reg;
    logic signed [FRAC_BITS+1:0] ui_ext, uo_ext;

    assign ui_ext = {1'b0, nar_uin[FRAC_BITS:0]};
    assign uo_ext = {1'b0, nar_uout[FRAC_BITS:0]};

    always_ff @(posedge clk)
    begin
        if (en[MUL_STAGE])
        begin
            psx_reg <= PW'(ui_ext * dx_pipe[NC-1]);
            psy_reg <= PW'(ui_ext * dy_pipe[NC-1]);
            pex_reg <= PW'(uo_ext * dx_pipe[NC-1]);
            pey_reg <= PW'(uo_ext * dy_pipe[NC-1]);
            mok_reg <= nar_ok;
            msx_reg <= sx_pipe[NC-1];
            msy_reg <= sy_pipe[NC-1];
            mdx_reg <= dx_pipe[NC-1];
            mdy_reg <= dy_pipe[NC-1];
        end
    end

    // round and output stage
    localparam logic signed [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);
    logic signed [PW-1:0] rsx, rsy, rex, rey;
    logic signed [DW-1:0] ex_full, ey_full;
    seg_out_t             out_next;

    always_comb
    begin
        rsx     = psx_reg + Half;
        rsy     = psy_reg + Half;
        rex     = pex_reg + Half;
        rey     = pey_reg + Half;
        ex_full = DW'(msx_reg) + mdx_reg;
        ey_full = DW'(msy_reg) + mdy_reg;
        if (mok_reg)
        begin
            out_next.clip_start_x = msx_reg + rsx[FRAC_BITS+CB-1:FRAC_BITS];
            out_next.clip_start_y = msy_reg + rsy[FRAC_BITS+CB-1:FRAC_BITS];
            out_next.clip_end_x   = msx_reg + rex[FRAC_BITS+CB-1:FRAC_BITS];
            out_next.clip_end_y   = msy_reg + rey[FRAC_BITS+CB-1:FRAC_BITS];
            out_next.visible      = 1'b1;
        end
        else
        begin
            out_next.clip_start_x = msx_reg;
            out_next.clip_start_y = msy_reg;
            out_next.clip_end_x   = ex_full[CB-1:0];
            out_next.clip_end_y   = ey_full[CB-1:0];
            out_next.visible      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
            out_data <= out_next;
    end

    `LSW_ASSERT(a_free_flow, !out_stall |-> !in_stall)
    `LSW_ASSERT_NEVER(a_param_order, v_reg[NAR_FIRST+3] && nar_ok && (nar_uin > nar_uout))
    `LSW_ASSERT_NEVER(a_param_range,
        v_reg[NAR_FIRST+3] && nar_ok &&
        ((nar_uin < 0) || (nar_uout > (RW'(1) << FRAC_BITS))))

endmodule

// ===== verif/line_segment_window_clipper_test.sv =====
// Testbench for line_segment_window_clipper: directed and random segments against a clip predictor.
module line_segment_window_clipper_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    localparam int  FracBits = FracBitsDefault;
    localparam longint Unit  = longint'(1) << FracBits;
    localparam int  Latency  = FracBits + 8;

    typedef struct {
        seg_in_t  seg;
        bit       typed;
        seg_out_t res;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    seg_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    seg_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CfgIndexBits-1:0]     cfg_index = CFG_LEFT;
    logic signed [CoordBits-1:0] cfg_data = '0;

    logic signed [CoordBits-1:0] win_left = LeftReset;
    logic signed [CoordBits-1:0] win_right = RightReset;
    logic signed [CoordBits-1:0] win_bottom = BottomReset;
    logic signed [CoordBits-1:0] win_top = TopReset;

    seg_out_t clipped_q[$];
    int       mismatches = 0;
    bit       quiet = 1'b0;
    int       stall_left = 0;

    line_segment_window_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint clip_ratio(longint n, longint d);
        if (n < 0)
            return -1;
        if (n > d)
            return Unit + 1;
        if (n == d)
            return Unit;
        return (n <<< FracBits) / d;
    endfunction

    function automatic bit clip_edge(longint p, longint q, inout longint u_in,
                                     inout longint u_out);
        longint r;
        if (p < 0) begin
            r = clip_ratio(-q, -p);
            if (r > u_out)
                return 1'b0;
            if (r > u_in)
                u_in = r;
        end
        else if (p > 0) begin
            r = clip_ratio(q, p);
            if (r < u_in)
                return 1'b0;
            if (r < u_out)
                u_out = r;
        end
        else if (q < 0) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [CoordBits-1:0] lerp_round(longint a, longint d, longint u);
        longint v;
        v = ((a <<< FracBits) + u * d + (Unit >>> 1)) >>> FracBits;
        return v[CoordBits-1:0];
    endfunction

    function automatic seg_out_t clip_segment(seg_in_t s);
        longint sx, sy, ex, ey, dx, dy, u_in, u_out;
        bit ok;
        seg_out_t o;
        sx = s.start_x;
        sy = s.start_y;
        ex = s.end_x;
        ey = s.end_y;
        dx = ex - sx;
        dy = ey - sy;
        u_in = 0;
        u_out = Unit;
        ok = clip_edge(-dx, sx - longint'(win_left), u_in, u_out)
            && clip_edge(dx, longint'(win_right) - sx, u_in, u_out)
            && clip_edge(-dy, sy - longint'(win_bottom), u_in, u_out)
            && clip_edge(dy, longint'(win_top) - sy, u_in, u_out);
        if (ok) begin
            o.clip_start_x = lerp_round(sx, dx, u_in);
            o.clip_start_y = lerp_round(sy, dy, u_in);
            o.clip_end_x = lerp_round(sx, dx, u_out);
            o.clip_end_y = lerp_round(sy, dy, u_out);
            o.visible = 1'b1;
        end
        else begin
            o = {s, 1'b0};
        end
        return o;
    endfunction

    // within 64 of the window span half the time, anywhere otherwise
    function automatic logic signed [CoordBits-1:0] pick_coord(longint a, longint b);
        longint lo, hi, v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if ($urandom_range(0, 1) == 0)
            return CoordBits'($urandom);
        v = lo - 64 + longint'($urandom_range(0, int'(hi - lo) + 128));
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[CoordBits-1:0];
    endfunction

    task automatic send_segment(seg_in_t s, bit typed, seg_out_t res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        clipped_q.push_back(typed ? res : clip_segment(s));
    endtask

    task automatic write_window(logic signed [CoordBits-1:0] l, logic signed [CoordBits-1:0] r,
                                logic signed [CoordBits-1:0] b, logic signed [CoordBits-1:0] t);
        logic signed [CoordBits-1:0] vals[4];
        logic [CfgIndexBits-1:0] idx[4];
        in_valid <= 1'b0;
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
        vals = '{l, r, b, t};
        idx = '{CFG_LEFT, CFG_RIGHT, CFG_BOTTOM, CFG_TOP};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        win_left = l;
        win_right = r;
        win_bottom = b;
        win_top = t;
    endtask

    task automatic report_field(string name, longint e, longint a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, e, a);
        end
    endtask

    always @(posedge clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk) begin
        seg_out_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (clipped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h", out_data);
            end
            else begin
                e = clipped_q.pop_front();
                report_field("clip_start_x", e.clip_start_x, out_data.clip_start_x);
                report_field("clip_start_y", e.clip_start_y, out_data.clip_start_y);
                report_field("clip_end_x", e.clip_end_x, out_data.clip_end_x);
                report_field("clip_end_y", e.clip_end_y, out_data.clip_end_y);
                report_field("visible", e.visible, out_data.visible);
            end
        end
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        logic signed [CoordBits-1:0] wl, wr, wb, wt;
        seg_in_t s;
        int wait_cycles;

        rows = '{
            '{'{16'sd10, 16'sd20, 16'sd200, 16'sd250}, 1'b1,
              '{16'sd10, 16'sd20, 16'sd200, 16'sd250, 1'b1}},
            '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1'b1, '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1}},
            '{'{-16'sd5, 16'sd10, -16'sd5, 16'sd200}, 1'b1,
              '{-16'sd5, 16'sd10, -16'sd5, 16'sd200, 1'b0}},
            '{'{16'sd10, 16'sd400, 16'sd200, 16'sd400}, 1'b1,
              '{16'sd10, 16'sd400, 16'sd200, 16'sd400, 1'b0}},
            '{'{16'sd0, 16'sd0, 16'sd300, 16'sd300}, 1'b1,
              '{16'sd0, 16'sd0, 16'sd300, 16'sd300, 1'b1}},
            '{'{16'sd300, 16'sd0, 16'sd300, 16'sd300}, 1'b1,
              '{16'sd300, 16'sd0, 16'sd300, 16'sd300, 1'b1}},
            '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b1,
              '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}},
            '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1,
              '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0}},
            '{'{-16'sd100, 16'sd150, 16'sd100, 16'sd150}, 1'b0, '0},
            '{'{-16'sd100, -16'sd100, 16'sd400, 16'sd400}, 1'b0, '0},
            '{'{16'sd400, 16'sd400, -16'sd100, -16'sd100}, 1'b0, '0},
            '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
            '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, 1'b0, '0},
            '{'{16'sh8000, 16'sd0, 16'sh7fff, 16'sd0}, 1'b0, '0},
            '{'{16'sd0, 16'sh8000, 16'sd0, 16'sh7fff}, 1'b0, '0},
            '{'{-16'sd10, 16'sd290, 16'sd20, 16'sd320}, 1'b0, '0},
            '{'{-16'sd1, 16'sd0, 16'sd1, 16'sd1}, 1'b0, '0},
            '{'{16'sd299, 16'sd1, 16'sd302, 16'sd4}, 1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed, rows[i].res);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin wl = LeftReset; wr = RightReset; wb = BottomReset; wt = TopReset; end
                1: begin wl = -16'sd100; wr = 16'sd100; wb = -16'sd50; wt = 16'sd50; end
                2: begin wl = 16'sh8000; wr = 16'sh7fff; wb = 16'sh8000; wt = 16'sh7fff; end
                3: begin wl = 16'sd200; wr = -16'sd200; wb = 16'sd100; wt = -16'sd100; end
                4: begin wl = 16'sd0; wr = 16'sd0; wb = 16'sd0; wt = 16'sd0; end
                5: begin wl = 16'sh7fff; wr = 16'sh7fff; wb = 16'sh8000; wt = 16'sh8000; end
                default: begin
                    wl = CoordBits'(int'($urandom_range(0, 2000)) - 1000);
                    wr = CoordBits'(int'(wl) + int'($urandom_range(1, 3000)));
                    wb = CoordBits'(int'($urandom_range(0, 2000)) - 1000);
                    wt = CoordBits'(int'(wb) + int'($urandom_range(1, 3000)));
                end
            endcase
            if (phase != 0)
                write_window(wl, wr, wb, wt);
            for (int n = 0; n < 128; n++) begin
                if (phase == 6 && n >= 40)
                    quiet = 1'b1;
                s.start_x = pick_coord(win_left, win_right);
                s.start_y = pick_coord(win_bottom, win_top);
                s.end_x = pick_coord(win_left, win_right);
                s.end_y = pick_coord(win_bottom, win_top);
                send_segment(s, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (clipped_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (Latency + 10) @(posedge clk);
        if (mismatches == 0 && clipped_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
